// ===== hdl/fdd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Finite-difference derivative package
// Shared constants, register indexes, mode codes and the tap coefficient table.
// ----------------------------------------------------------------------------
package fdd_pkg;

    // History and coefficient geometry
    localparam int HIST_DEPTH   = 7;
    localparam int AGE_W        = 3;
    localparam int FILL_W       = 3;
    localparam int COEF_W       = 14;
    localparam int MODE_W       = 3;

    // Configuration port
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 32;

    // Scaling arithmetic
    localparam int SCALE_W      = 32;
    localparam int SCALE_HALF_W = 16;
    localparam int FRAC_BITS    = 24;
    localparam int OUT_W        = 32;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MODE         = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_SCALE  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SECOND_SCALE = 2'd2;

    // Estimator modes
    localparam logic [MODE_W-1:0] MODE_FD1_2PT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FD1_6PT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FD2_3PT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FD2_6PT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SG2_5PT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SG2_7PT = 3'd5;

    // Tap coefficient, scaled by 420, for a given mode and sample age
    // (age 0 is the newest sample). Unused modes give all-zero taps.
    function automatic logic signed [COEF_W-1:0] tap_coef(
        input logic [MODE_W-1:0] mode,
        input logic [AGE_W-1:0]  age
    );
        logic signed [COEF_W-1:0] c;
        c = '0;
        case (mode)
            MODE_FD1_2PT:
            begin
                case (age)
                    3'd0:    c = 14'sd420;
                    3'd1:    c = -14'sd420;
                    default: c = '0;
                endcase
            end
            MODE_FD1_6PT:
            begin
                case (age)
                    3'd0:    c = 14'sd959;
                    3'd1:    c = -14'sd2100;
                    3'd2:    c = 14'sd2100;
                    3'd3:    c = -14'sd1400;
                    3'd4:    c = 14'sd525;
                    3'd5:    c = -14'sd84;
                    default: c = '0;
                endcase
            end
            MODE_FD2_3PT:
            begin
                case (age)
                    3'd0:    c = 14'sd420;
                    3'd1:    c = -14'sd840;
                    3'd2:    c = 14'sd420;
                    default: c = '0;
                endcase
            end
            MODE_FD2_6PT:
            begin
                case (age)
                    3'd0:    c = 14'sd1575;
                    3'd1:    c = -14'sd5390;
                    3'd2:    c = 14'sd7490;
                    3'd3:    c = -14'sd5460;
                    3'd4:    c = 14'sd2135;
                    3'd5:    c = -14'sd350;
                    default: c = '0;
                endcase
            end
            MODE_SG2_5PT:
            begin
                case (age)
                    3'd0:    c = 14'sd120;
                    3'd1:    c = -14'sd60;
                    3'd2:    c = -14'sd120;
                    3'd3:    c = -14'sd60;
                    3'd4:    c = 14'sd120;
                    default: c = '0;
                endcase
            end
            MODE_SG2_7PT:
            begin
                case (age)
                    3'd0:    c = 14'sd50;
                    3'd2:    c = -14'sd30;
                    3'd3:    c = -14'sd40;
                    3'd4:    c = -14'sd30;
                    3'd6:    c = 14'sd50;
                    default: c = '0;
                endcase
            end
            default: c = '0;
        endcase
        return c;
    endfunction

    // Number of samples a mode needs before its estimate is meaningful.
    function automatic logic [FILL_W-1:0] taps_needed(input logic [MODE_W-1:0] mode);
        logic [FILL_W-1:0] n;
        case (mode)
            MODE_FD1_2PT: n = 3'd2;
            MODE_FD1_6PT: n = 3'd6;
            MODE_FD2_3PT: n = 3'd3;
            MODE_FD2_6PT: n = 3'd6;
            MODE_SG2_5PT: n = 3'd5;
            MODE_SG2_7PT: n = 3'd7;
            default:      n = '0;
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/finite_difference_derivative.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Finite-difference derivative estimator
// Backward finite-difference and Savitzky-Golay derivative over a seven-sample
// history, scaled by a Q8.24 step factor and saturated to 32 bits.
// ----------------------------------------------------------------------------
// The block takes one signed sample per request and returns one derivative per
// request, in order. It sustains one request per clock. The capture stage takes
// the sample at the accepting edge, and the result then passes through the six
// later register stages (tap multiply, two adder levels, the split scale
// multiply, the recombine shift and the saturation stage) to the output. Each
// stage holds its own valid bit, so bubbles close up and a stalled output only
// stops the input once every stage is full. The estimate is the tap sum
// (coefficients times 420) multiplied by first_step_scale for the
// first-derivative modes or second_step_scale for the second-derivative modes,
// floored by 2^24 and saturated. history_ready in tuser tells whether enough
// samples have been seen for the selected mode; before that, missing samples
// count as zero. Modes 6 and 7 produce zero with history_ready low.
// Configuration is to be written by the user only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module finite_difference_derivative #(
    parameter int SAMPLE_BITS = 16,
    localparam int IN_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,

    // Configuration write port
    input  logic                               cfg_we,
    input  logic [fdd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [fdd_pkg::CFG_DATA_W-1:0]     cfg_data,

    // Sample input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [IN_TDATA_W-1:0]              s_axis_tdata,  // sample

    // Derivative output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [fdd_pkg::OUT_W-1:0]          m_axis_tdata,  // derivative
    output logic                               m_axis_tuser   // history_ready
);

    // ------------------------------------------------------------------------
    // Widths
    // ------------------------------------------------------------------------
    localparam int SW      = SAMPLE_BITS;
    localparam int PROD_W  = SW + fdd_pkg::COEF_W;
    localparam int PAIR_W  = PROD_W + 1;
    localparam int SUM_W   = PROD_W + 3;
    localparam int PART_W  = SUM_W + fdd_pkg::SCALE_HALF_W + 1;
    localparam int FULL_W  = SUM_W + fdd_pkg::SCALE_W + 1;
    localparam int SH_W    = FULL_W - fdd_pkg::FRAC_BITS;
    localparam int NSTG    = 7;

    localparam int ST_A = 0;  // history capture
    localparam int ST_B = 1;  // tap products
    localparam int ST_C = 2;  // pair sums
    localparam int ST_D = 3;  // tap sum
    localparam int ST_E = 4;  // partial scale products
    localparam int ST_F = 5;  // recombine and shift
    localparam int ST_G = 6;  // saturate, output register

    localparam logic [fdd_pkg::FILL_W-1:0] FILL_FULL = fdd_pkg::FILL_W'(fdd_pkg::HIST_DEPTH);

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [fdd_pkg::MODE_W-1:0]  mode_reg;
    logic [fdd_pkg::SCALE_W-1:0] first_scale_reg;
    logic [fdd_pkg::SCALE_W-1:0] second_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= '0;
            first_scale_reg  <= '0;
            second_scale_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                fdd_pkg::REG_MODE:         mode_reg <= cfg_data[fdd_pkg::MODE_W-1:0];
                fdd_pkg::REG_FIRST_SCALE:  first_scale_reg <= cfg_data;
                fdd_pkg::REG_SECOND_SCALE: second_scale_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline flow control: a stage can take new data when it is empty or
    // its own content moves on in the same cycle.
    // ------------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] rdy;
    logic            accept;

    always_comb
    begin
        rdy[ST_G] = !vld_reg[ST_G] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_axis_tready = rdy[ST_A];
    assign accept        = s_axis_tvalid && rdy[ST_A];

    always_comb
    begin
        vld_next = vld_reg;
        if (rdy[ST_A])
        begin
            vld_next[ST_A] = s_axis_tvalid;
        end
        for (int k = 1; k < NSTG; k++)
        begin
            if (rdy[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage A: sample history and per-request settings. The history array is
    // also the window that stage B reads; it changes only on an accepted
    // request, so it holds while stage A is stalled.
    // ------------------------------------------------------------------------
    logic signed [SW-1:0]          hist_reg [fdd_pkg::HIST_DEPTH];
    logic [fdd_pkg::FILL_W-1:0]    fill_reg;
    logic [fdd_pkg::FILL_W-1:0]    fill_next;
    logic [fdd_pkg::MODE_W-1:0]    a_mode_reg;
    logic [fdd_pkg::SCALE_W-1:0]   a_scale_reg;
    logic [fdd_pkg::SCALE_W-1:0]   a_scale_next;
    logic                          a_ready_reg;
    logic                          a_ready_next;
    logic                          mode_valid;

    always_comb
    begin
        fill_next = (fill_reg == FILL_FULL) ? fill_reg : fill_reg + 1'b1;
        case (mode_reg)
            fdd_pkg::MODE_FD1_2PT,
            fdd_pkg::MODE_FD1_6PT:
            begin
                a_scale_next = first_scale_reg;
                mode_valid   = 1'b1;
            end
            fdd_pkg::MODE_FD2_3PT,
            fdd_pkg::MODE_FD2_6PT,
            fdd_pkg::MODE_SG2_5PT,
            fdd_pkg::MODE_SG2_7PT:
            begin
                a_scale_next = second_scale_reg;
                mode_valid   = 1'b1;
            end
            default:
            begin
                // An unused mode has zero taps and zero scale, so it yields zero.
                a_scale_next = '0;
                mode_valid   = 1'b0;
            end
        endcase
        a_ready_next = mode_valid && (fill_next >= fdd_pkg::taps_needed(mode_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            for (int i = 0; i < fdd_pkg::HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            fill_reg    <= fill_next;
            hist_reg[0] <= $signed(s_axis_tdata[SW-1:0]);
            for (int i = 1; i < fdd_pkg::HIST_DEPTH; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_mode_reg  <= mode_reg;
            a_scale_reg <= a_scale_next;
            a_ready_reg <= a_ready_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage B: one constant-coefficient product per tap.
    // ------------------------------------------------------------------------
    logic signed [PROD_W-1:0]      b_prod_reg [fdd_pkg::HIST_DEPTH];
    logic signed [PROD_W-1:0]      b_prod_next [fdd_pkg::HIST_DEPTH];
    logic [fdd_pkg::SCALE_W-1:0]   b_scale_reg;
    logic                          b_ready_reg;

    always_comb
    begin
        for (int i = 0; i < fdd_pkg::HIST_DEPTH; i++)
        begin
            b_prod_next[i] = PROD_W'(hist_reg[i]) *
                             PROD_W'(fdd_pkg::tap_coef(a_mode_reg, fdd_pkg::AGE_W'(i)));
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_B])
        begin
            b_prod_reg  <= b_prod_next;
            b_scale_reg <= a_scale_reg;
            b_ready_reg <= a_ready_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage C: first adder level.
    // ------------------------------------------------------------------------
    logic signed [PAIR_W-1:0]      c_pair_reg [4];
    logic [fdd_pkg::SCALE_W-1:0]   c_scale_reg;
    logic                          c_ready_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[ST_C])
        begin
            c_pair_reg[0] <= PAIR_W'(b_prod_reg[0]) + PAIR_W'(b_prod_reg[1]);
            c_pair_reg[1] <= PAIR_W'(b_prod_reg[2]) + PAIR_W'(b_prod_reg[3]);
            c_pair_reg[2] <= PAIR_W'(b_prod_reg[4]) + PAIR_W'(b_prod_reg[5]);
            c_pair_reg[3] <= PAIR_W'(b_prod_reg[6]);
            c_scale_reg   <= b_scale_reg;
            c_ready_reg   <= b_ready_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage D: complete tap sum.
    // ------------------------------------------------------------------------
    logic signed [SUM_W-1:0]       d_sum_reg;
    logic [fdd_pkg::SCALE_W-1:0]   d_scale_reg;
    logic                          d_ready_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[ST_D])
        begin
            d_sum_reg   <= (SUM_W'(c_pair_reg[0]) + SUM_W'(c_pair_reg[1])) +
                           (SUM_W'(c_pair_reg[2]) + SUM_W'(c_pair_reg[3]));
            d_scale_reg <= c_scale_reg;
            d_ready_reg <= c_ready_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage E: the sum times each 16-bit half of the scale.
    // ------------------------------------------------------------------------
    logic signed [PART_W-1:0]      e_hi_reg;
    logic signed [PART_W-1:0]      e_lo_reg;
    logic                          e_ready_reg;
    logic signed [PART_W-1:0]      scale_hi_ext;
    logic signed [PART_W-1:0]      scale_lo_ext;

    assign scale_hi_ext = PART_W'($signed({1'b0,
        d_scale_reg[fdd_pkg::SCALE_W-1:fdd_pkg::SCALE_HALF_W]}));
    assign scale_lo_ext = PART_W'($signed({1'b0,
        d_scale_reg[fdd_pkg::SCALE_HALF_W-1:0]}));

    always_ff @(posedge clk)
    begin
        if (rdy[ST_E])
        begin
            e_hi_reg    <= PART_W'(d_sum_reg) * scale_hi_ext;
            e_lo_reg    <= PART_W'(d_sum_reg) * scale_lo_ext;
            e_ready_reg <= d_ready_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage F: recombine the halves; dropping the low fraction bits of the
    // two's complement product is a floor division by 2^24.
    // ------------------------------------------------------------------------
    logic signed [FULL_W-1:0]      full_prod;
    logic signed [SH_W-1:0]        f_val_reg;
    logic                          f_ready_reg;

    assign full_prod = (FULL_W'(e_hi_reg) <<< fdd_pkg::SCALE_HALF_W) + FULL_W'(e_lo_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[ST_F])
        begin
            f_val_reg   <= $signed(full_prod[FULL_W-1:fdd_pkg::FRAC_BITS]);
            f_ready_reg <= e_ready_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage G: saturate to 32-bit signed; this is the output register.
    // ------------------------------------------------------------------------
    localparam logic [fdd_pkg::OUT_W-1:0] OUT_MAX = {1'b0, {(fdd_pkg::OUT_W-1){1'b1}}};
    localparam logic [fdd_pkg::OUT_W-1:0] OUT_MIN = {1'b1, {(fdd_pkg::OUT_W-1){1'b0}}};

    logic [fdd_pkg::OUT_W-1:0]     g_deriv_reg;
    logic [fdd_pkg::OUT_W-1:0]     g_deriv_next;
    logic                          g_ready_reg;
    logic                          f_ovf_pos;
    logic                          f_ovf_neg;

    always_comb
    begin
        f_ovf_pos = !f_val_reg[SH_W-1] &&  (|f_val_reg[SH_W-2:fdd_pkg::OUT_W-1]);
        f_ovf_neg =  f_val_reg[SH_W-1] && !(&f_val_reg[SH_W-2:fdd_pkg::OUT_W-1]);
        if (f_ovf_pos)
        begin
            g_deriv_next = OUT_MAX;
        end
        else if (f_ovf_neg)
        begin
            g_deriv_next = OUT_MIN;
        end
        else
        begin
            g_deriv_next = f_val_reg[fdd_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_G])
        begin
            g_deriv_reg <= g_deriv_next;
            g_ready_reg <= f_ready_reg;
        end
    end

    assign m_axis_tvalid = vld_reg[ST_G];
    assign m_axis_tdata  = g_deriv_reg;
    assign m_axis_tuser  = g_ready_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`ifndef SYNTHESIS
    // The input only stalls when every stage is full and the output is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> ((&vld_reg) && !m_axis_tready))
        else $error("input stalled while the pipeline still has room");

    // The fill count steps by one per accepted sample until it saturates.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (fill_reg != FILL_FULL)) |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("fill count did not advance on an accepted sample");

    // Unused modes must carry zero scale and a low ready flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[ST_A] && (a_mode_reg > fdd_pkg::MODE_SG2_7PT))
            |-> (!a_ready_reg && (a_scale_reg == '0)))
        else $error("unused mode carries a scale or a ready flag");

    // No mode is ready before at least two samples have been seen.
    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[ST_A] && a_ready_reg) |-> (fill_reg >= 3'd2))
        else $error("history flagged ready with too few samples");

    // A positive overflow leaving stage F must appear as the maximum value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rdy[ST_G] && vld_reg[ST_F] && f_ovf_pos) |=> (g_deriv_reg == OUT_MAX))
        else $error("positive overflow not saturated");
`endif

endmodule
